// ===== rtl/pidc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, register codes and constants of the clamped PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Default sizes of the sample and integral paths
  localparam int unsigned SAMPLE_WIDTH   = 16;
  localparam int unsigned INTEGRAL_WIDTH = 48;

  // Fixed field widths
  localparam int unsigned DATA_W    = 16;
  localparam int unsigned OUT_W     = 10;
  localparam int unsigned CFG_IDX_W = 3;

  // Reset values of the configuration registers
  localparam logic [DATA_W-1:0] TS_RESET      = 16'd1;
  localparam logic [OUT_W-1:0]  OUT_MAX_RESET = 10'd980;
  localparam logic [OUT_W-1:0]  OUT_MIN_RESET = 10'd20;

  // Sequencer step counts
  localparam int unsigned MUL_STEPS = 4;  // one 4-bit digit of the gain per step
  localparam int unsigned ADD_STEPS = 5;

  // Wide intermediates saturate at +/-2^62; sums are formed at 65 bits
  localparam int unsigned SUM_W = 65;
  localparam logic [63:0] WIDE_LIM = 64'h4000_0000_0000_0000;
  localparam logic signed [SUM_W-1:0] SUM_HI = 65'sh0_4000_0000_0000_0000;
  localparam logic signed [SUM_W-1:0] SUM_LO = 65'sh1_C000_0000_0000_0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP      = 3'd0,
    REG_KI      = 3'd1,
    REG_KD      = 3'd2,
    REG_OFFSET  = 3'd3,
    REG_TS      = 3'd4,
    REG_OUT_MAX = 3'd5,
    REG_OUT_MIN = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [DATA_W-1:0]        kp;
    logic [DATA_W-1:0]        ki;
    logic [DATA_W-1:0]        kd;
    logic signed [DATA_W-1:0] offset;
    logic [DATA_W-1:0]        ts;
    logic [OUT_W-1:0]         out_max;
    logic [OUT_W-1:0]         out_min;
  } cfg_t;

  // Multiplier operand pairs
  typedef enum logic [1:0] {
    MUL_P = 2'd0,  // |err| * kp
    MUL_I = 2'd1,  // |err| * ki
    MUL_T = 2'd2,  // (|err| * ki) * time_step
    MUL_D = 2'd3   // |prev - meas| * kd
  } mul_sel_e;

  // Terms of the output sum, in order
  typedef enum logic [2:0] {
    ADD_P   = 3'd0,
    ADD_INT = 3'd1,
    ADD_DI  = 3'd2,
    ADD_D   = 3'd3,
    ADD_OFF = 3'd4
  } add_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    logic     mul_first;
    logic     mul_last;
    mul_sel_e mul_sel;
    logic [1:0] nib_idx;
    logic     div_en;
    logic     div_first;
    logic     add_en;
    add_sel_e add_sel;
    logic     finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;  // result register holds an item the receiver stalls on
  } ctrl_sts_t;

endpackage

// ===== rtl/pid_controller_clamped.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Integer PID step with output limits and conditional-integration anti-windup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item per control tick:
//   setpoint and sensor reading. Output channel (out_valid_o / out_stall_i)
//   returns the limited drive value and a flag that the limit was hit.
//   Config port (cfg_valid_i / cfg_ready_o) writes gains, offset, time step
//   and limits; always ready. Write only while idle; the block does not check.
//   Each item runs through a shared 4-bit-digit multiplier (4 products),
//   a divider retiring 2 quotient bits per cycle over DIV_STEPS =
//   (SAMPLE_WIDTH + 18) / 2 steps, 5 summing steps and one limit step.
//   A new item is taken only once the previous one has left its limit step.
//   A result register separates the output: while the receiver stalls, the
//   next item is accepted and computed, and waits only at its limit step.
//   Reset clears integral, previous reading and all control state, and
//   loads time step 1 and limits 20 / 980.
// ----------------------------------------------------------------------------
module pid_controller_clamped #(
  parameter int unsigned SAMPLE_WIDTH   = pidc_pkg::SAMPLE_WIDTH,
  parameter int unsigned INTEGRAL_WIDTH = pidc_pkg::INTEGRAL_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    target_value_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    measured_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pidc_pkg::OUT_W-1:0]        drive_value_o,
  output logic                              was_clamped_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pidc_pkg::DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned DIV_STEPS = (SAMPLE_WIDTH + 18) / 2;

  pidc_pkg::cfg_t      cfg;
  pidc_pkg::ctrl_cmd_t cmd;
  pidc_pkg::ctrl_sts_t sts;

  pidc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pidc_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pidc_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH),
    .DIV_STEPS      (DIV_STEPS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_i            (cfg),
    .target_value_i   (target_value_i),
    .measured_value_i (measured_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_value_o    (drive_value_o),
    .was_clamped_o    (was_clamped_o)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the input side busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not held off after accepting an item");

  // A new result only comes out of an item in flight
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an item in flight");

  // The sequencer drives one datapath operation at a time
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.mul_en, cmd.div_en, cmd.add_en, cmd.finish}))
    else $error("more than one datapath operation commanded");
`endif

endmodule

// ===== rtl/pidc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_cfg
// Configuration register file: gains, offset, time step and output limits.
// ----------------------------------------------------------------------------
module pidc_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pidc_pkg::DATA_W-1:0]        cfg_data_i,
  output pidc_pkg::cfg_t                     cfg_o
);

  pidc_pkg::cfg_t cfg_q;

  // Writes must only arrive while idle (unchecked); the port never holds off
  assign cfg_ready_o = 1'b1;

  // Register write; unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp      <= '0;
      cfg_q.ki      <= '0;
      cfg_q.kd      <= '0;
      cfg_q.offset  <= '0;
      cfg_q.ts      <= pidc_pkg::TS_RESET;
      cfg_q.out_max <= pidc_pkg::OUT_MAX_RESET;
      cfg_q.out_min <= pidc_pkg::OUT_MIN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (pidc_pkg::cfg_reg_e'(cfg_index_i))
        pidc_pkg::REG_KP:      cfg_q.kp      <= cfg_data_i;
        pidc_pkg::REG_KI:      cfg_q.ki      <= cfg_data_i;
        pidc_pkg::REG_KD:      cfg_q.kd      <= cfg_data_i;
        pidc_pkg::REG_OFFSET:  cfg_q.offset  <= cfg_data_i;
        pidc_pkg::REG_TS:      cfg_q.ts      <= cfg_data_i;
        pidc_pkg::REG_OUT_MAX: cfg_q.out_max <= cfg_data_i[pidc_pkg::OUT_W-1:0];
        pidc_pkg::REG_OUT_MIN: cfg_q.out_min <= cfg_data_i[pidc_pkg::OUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/pidc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_ctrl
// Sequencer: steps the datapath through multiply, divide, sum and limit.
// ----------------------------------------------------------------------------
module pidc_ctrl #(
  parameter int unsigned DIV_STEPS = 17
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pidc_pkg::ctrl_sts_t   sts_i,
  output pidc_pkg::ctrl_cmd_t   cmd_o
);

  localparam int unsigned CNTW = $clog2(DIV_STEPS);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL_P = 8'b0000_0010,
    S_MUL_I = 8'b0000_0100,
    S_MUL_T = 8'b0000_1000,
    S_MUL_D = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_ADD   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic              mul_last;
  logic              cnt_zero;

  assign cnt_zero = (cnt_q == '0);
  assign mul_last = (cnt_q == CNTW'(pidc_pkg::MUL_STEPS - 1));

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.mul_first = cnt_zero;
    cmd_o.mul_last  = mul_last;
    cmd_o.nib_idx   = cnt_q[1:0];
    cmd_o.div_first = cnt_zero;
    cmd_o.add_sel   = pidc_pkg::add_sel_e'(cnt_q[2:0]);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_MUL_P;
        end
      end
      S_MUL_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidc_pkg::MUL_P;
        cnt_d = mul_last ? '0 : cnt_q + 1'b1;
        if (mul_last) state_d = S_MUL_I;
      end
      S_MUL_I: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidc_pkg::MUL_I;
        cnt_d = mul_last ? '0 : cnt_q + 1'b1;
        if (mul_last) state_d = S_MUL_T;
      end
      S_MUL_T: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidc_pkg::MUL_T;
        cnt_d = mul_last ? '0 : cnt_q + 1'b1;
        if (mul_last) state_d = S_MUL_D;
      end
      S_MUL_D: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidc_pkg::MUL_D;
        cnt_d = mul_last ? '0 : cnt_q + 1'b1;
        if (mul_last) state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_en = 1'b1;
        if (cnt_q == CNTW'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_ADD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ADD: begin
        cmd_o.add_en = 1'b1;
        if (cnt_q == CNTW'(pidc_pkg::ADD_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FIN: begin
        // wait for room in the result register
        if (!sts_i.out_full) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== rtl/pidc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_datapath
// Error terms, digit-serial multiplier, radix-4 divider, saturating summer,
// output limit, integral and previous-reading state, result register.
// ----------------------------------------------------------------------------
module pidc_datapath #(
  parameter int unsigned SAMPLE_WIDTH   = pidc_pkg::SAMPLE_WIDTH,
  parameter int unsigned INTEGRAL_WIDTH = pidc_pkg::INTEGRAL_WIDTH,
  parameter int unsigned DIV_STEPS      = 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pidc_pkg::ctrl_cmd_t               cmd_i,
  output pidc_pkg::ctrl_sts_t               sts_o,
  input  pidc_pkg::cfg_t                    cfg_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    target_value_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    measured_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pidc_pkg::OUT_W-1:0]        drive_value_o,
  output logic                              was_clamped_o
);

  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned IW   = INTEGRAL_WIDTH;
  localparam int unsigned DTW  = pidc_pkg::DATA_W;
  localparam int unsigned EW   = SW + 1;            // error and reading difference
  localparam int unsigned AW   = SW + 17;           // multiplier operand magnitude
  localparam int unsigned PRW  = AW + 16;           // product magnitude
  localparam int unsigned XW   = (PRW > 63) ? PRW : 63;
  localparam int unsigned DIW  = (PRW < 63) ? PRW : 63;
  localparam int unsigned DW   = 2 * DIV_STEPS;     // padded dividend
  localparam int unsigned SUMW = pidc_pkg::SUM_W;
  localparam int unsigned OW   = pidc_pkg::OUT_W;

  localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

  // State and working registers
  logic signed [SW-1:0]     prev_q;
  logic signed [IW-1:0]     integral_q;
  logic                     err_neg_q, dm_neg_q;
  logic [EW-1:0]            err_mag_q, dm_mag_q;
  logic [PRW-1:0]           acc_q;
  logic [AW-1:0]            p_mag_q, t_mag_q, dp_mag_q;
  logic [DIW-1:0]           di_mag_q;
  logic [DW-1:0]            quo_q;
  logic [DTW-1:0]           rem_q;
  logic signed [SUMW-2:0]   sum_q;
  logic                     out_valid_q;
  logic [OW-1:0]            drive_q;
  logic                     clamped_q;

  // ---- item load: error and reading difference as sign and magnitude ----
  logic signed [EW-1:0] err, dm;
  logic [EW-1:0]        err_mag, dm_mag;

  always_comb begin
    err     = EW'(target_value_i) - EW'(measured_value_i);
    dm      = EW'(prev_q) - EW'(measured_value_i);
    err_mag = err[EW-1] ? EW'(-err) : EW'(err);
    dm_mag  = dm[EW-1] ? EW'(-dm) : EW'(dm);
  end

  // ---- multiplier: one 4-bit digit of the gain per cycle, MSB first ----
  logic [AW-1:0]  mul_a;
  logic [DTW-1:0] mul_b;
  logic [3:0]     nib;
  logic [AW+3:0]  pn;
  logic [PRW-1:0] acc_base, acc_d;
  logic [XW-1:0]  prod_x, sat_x;
  logic [DIW-1:0] di_mag_d;

  always_comb begin
    case (cmd_i.mul_sel)
      pidc_pkg::MUL_P: begin mul_a = AW'(err_mag_q); mul_b = cfg_i.kp; end
      pidc_pkg::MUL_I: begin mul_a = AW'(err_mag_q); mul_b = cfg_i.ki; end
      pidc_pkg::MUL_T: begin mul_a = t_mag_q;        mul_b = cfg_i.ts; end
      pidc_pkg::MUL_D: begin mul_a = AW'(dm_mag_q);  mul_b = cfg_i.kd; end
      default:         begin mul_a = '0;             mul_b = '0;       end
    endcase
    case (cmd_i.nib_idx)
      2'd0:    nib = mul_b[15:12];
      2'd1:    nib = mul_b[11:8];
      2'd2:    nib = mul_b[7:4];
      default: nib = mul_b[3:0];
    endcase
    pn       = (AW+4)'(mul_a) * (AW+4)'(nib);
    acc_base = cmd_i.mul_first ? '0 : acc_q;
    acc_d    = {acc_base[PRW-5:0], 4'b0000} + PRW'(pn);
    // saturate the integral step at 2^62
    prod_x   = XW'(acc_d);
    sat_x    = (prod_x > XW'(pidc_pkg::WIDE_LIM)) ? XW'(pidc_pkg::WIDE_LIM) : prod_x;
    di_mag_d = DIW'(sat_x);
  end

  // ---- divider: two restoring steps per cycle ----
  logic [DTW-1:0] divisor;
  logic [DW-1:0]  q_src, q_mid, q_nxt;
  logic [DTW-1:0] r_src, r_mid, r_nxt;
  logic [DTW:0]   r1, r2;

  always_comb begin
    divisor = (cfg_i.ts == '0) ? DTW'(1) : cfg_i.ts;
    q_src   = cmd_i.div_first ? DW'(dp_mag_q) : quo_q;
    r_src   = cmd_i.div_first ? '0 : rem_q;
    // first bit
    r1    = {r_src, q_src[DW-1]};
    q_mid = {q_src[DW-2:0], 1'b0};
    if (r1 >= {1'b0, divisor}) begin
      r1       = r1 - {1'b0, divisor};
      q_mid[0] = 1'b1;
    end
    r_mid = r1[DTW-1:0];
    // second bit
    r2    = {r_mid, q_mid[DW-1]};
    q_nxt = {q_mid[DW-2:0], 1'b0};
    if (r2 >= {1'b0, divisor}) begin
      r2       = r2 - {1'b0, divisor};
      q_nxt[0] = 1'b1;
    end
    r_nxt = r2[DTW-1:0];
  end

  // ---- summer: one saturating add per cycle ----
  logic signed [SUMW-1:0] int_x, int_c;
  logic signed [SUMW-1:0] base, op, raw, raw_c;
  logic [SUMW-1:0]        mag;
  logic                   neg, is_mag;

  always_comb begin
    int_x = SUMW'(integral_q);
    if (int_x > pidc_pkg::SUM_HI) int_c = pidc_pkg::SUM_HI;
    else if (int_x < pidc_pkg::SUM_LO) int_c = pidc_pkg::SUM_LO;
    else int_c = int_x;

    base   = (cmd_i.add_sel == pidc_pkg::ADD_P) ? '0 : SUMW'(sum_q);
    mag    = '0;
    neg    = 1'b0;
    is_mag = 1'b1;
    op     = '0;
    case (cmd_i.add_sel)
      pidc_pkg::ADD_P:   begin mag = SUMW'(p_mag_q);        neg = err_neg_q; end
      pidc_pkg::ADD_INT: begin is_mag = 1'b0; op = int_c; end
      pidc_pkg::ADD_DI:  begin mag = SUMW'(di_mag_q);       neg = err_neg_q; end
      pidc_pkg::ADD_D:   begin mag = SUMW'(quo_q[AW-1:0]);  neg = dm_neg_q;  end
      pidc_pkg::ADD_OFF: begin
        is_mag = 1'b0;
        op     = {{(SUMW-DTW){cfg_i.offset[DTW-1]}}, cfg_i.offset};
      end
      default: ;
    endcase
    if (is_mag) begin
      op = neg ? ~mag : mag;
    end
    raw = base + op + SUMW'(is_mag & neg);
    if (raw > pidc_pkg::SUM_HI) raw_c = pidc_pkg::SUM_HI;
    else if (raw < pidc_pkg::SUM_LO) raw_c = pidc_pkg::SUM_LO;
    else raw_c = raw;
  end

  // ---- output limit and integral update ----
  logic signed [SUMW-2:0] max_x, min_x;
  logic                   over, under;
  logic signed [SUMW-1:0] di_op, int_new;
  logic [SUMW-1:0]        di_ext;
  logic [IW-1:0]          int_sat;
  logic [OW-1:0]          drive_d;

  always_comb begin
    max_x  = {{(SUMW-1-OW){1'b0}}, cfg_i.out_max};
    min_x  = {{(SUMW-1-OW){1'b0}}, cfg_i.out_min};
    over   = (sum_q > max_x);
    under  = !over && (sum_q < min_x);
    di_ext = SUMW'(di_mag_q);
    di_op  = err_neg_q ? ~di_ext : di_ext;
    int_new = SUMW'(integral_q) + di_op + SUMW'(err_neg_q);
    if (int_new > SUMW'(IMAX)) int_sat = IMAX;
    else if (int_new < SUMW'(IMIN)) int_sat = IMIN;
    else int_sat = int_new[IW-1:0];
    if (over) drive_d = cfg_i.out_max;
    else if (under) drive_d = cfg_i.out_min;
    else drive_d = sum_q[OW-1:0];
  end

  // Controller state: readings, integral, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      integral_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        prev_q <= measured_value_i;
      end
      if (cmd_i.finish && !over && !under) begin
        integral_q <= int_sat;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_neg_q <= err[EW-1];
      err_mag_q <= err_mag;
      dm_neg_q  <= dm[EW-1];
      dm_mag_q  <= dm_mag;
    end
    if (cmd_i.mul_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.mul_en && cmd_i.mul_last) begin
      case (cmd_i.mul_sel)
        pidc_pkg::MUL_P: p_mag_q  <= AW'(acc_d);
        pidc_pkg::MUL_I: t_mag_q  <= AW'(acc_d);
        pidc_pkg::MUL_T: di_mag_q <= di_mag_d;
        pidc_pkg::MUL_D: dp_mag_q <= AW'(acc_d);
        default: ;
      endcase
    end
    if (cmd_i.div_en) begin
      quo_q <= q_nxt;
      rem_q <= r_nxt;
    end
    if (cmd_i.add_en) begin
      sum_q <= raw_c[SUMW-2:0];
    end
    if (cmd_i.finish) begin
      drive_q   <= drive_d;
      clamped_q <= over || under;
    end
  end

  assign sts_o.out_full = out_valid_q && out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign drive_value_o  = drive_q;
  assign was_clamped_o  = clamped_q;

endmodule
